/* sv/ifs_fractal_point_generator_macros.svh */
// assertion macros used by the point generator back part
`ifndef IFS_FRACTAL_POINT_GENERATOR_MACROS_SVH
`define IFS_FRACTAL_POINT_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define IFSFPG_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifsfpg check failed");

// next-cycle implication, clocked on clk, quiet while rst_n is low
`define IFSFPG_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifsfpg check failed");

`endif

/* sv/ifsfpg_pkg.sv */
// shared types and constants of the chaos-game point generator
package ifsfpg_pkg;

    localparam int DEFAULT_FRACTION_BITS = 16;
    localparam int QUEUE_DEPTH           = 2;
    localparam int CFG_WIDTH             = 12;
    localparam int CFG_INDEX_WIDTH       = 2;
    localparam int PIXEL_WIDTH           = 12;

    // map set codes
    localparam logic [1:0] MAP_SET_LINE   = 2'd0;
    localparam logic [1:0] MAP_SET_SQUARE = 2'd1;
    localparam logic [1:0] MAP_SET_KOCH   = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAP_SET       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_HEIGHT = 2'd2;

    localparam logic [1:0]             RESET_MAP_SET = MAP_SET_KOCH;
    localparam logic [PIXEL_WIDTH-1:0] RESET_WINDOW  = 12'd800;

    typedef enum logic [3:0] {
        KIND_SHRINK_HALF  = 4'd0,
        KIND_LINE_TOP     = 4'd1,
        KIND_SQUARE_UP    = 4'd2,
        KIND_SQUARE_RIGHT = 4'd3,
        KIND_SQUARE_FLIP  = 4'd4,
        KIND_KOCH_LEFT    = 4'd5,
        KIND_KOCH_RISE    = 4'd6,
        KIND_KOCH_FALL    = 4'd7,
        KIND_KOCH_RIGHT   = 4'd8
    } map_kind_t;

    typedef struct packed {
        map_kind_t  kind;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [PIXEL_WIDTH-1:0] width;
        logic [PIXEL_WIDTH-1:0] height;
    } window_t;

    typedef struct packed {
        logic [PIXEL_WIDTH-1:0] pixel_x;
        logic [PIXEL_WIDTH-1:0] pixel_y;
        logic [1:0]             map_index;
    } result_t;

endpackage

/* sv/ifsfpg_queue.sv */
// small register queue between pipeline parts
module ifsfpg_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/ifsfpg_front.sv */
// front part: takes draws and picks the affine map to apply
module ifsfpg_front (
    input  logic              push,
    input  logic              full,
    input  logic [15:0]       draw,
    input  logic [1:0]        map_set,
    output logic              cmd_push,
    output ifsfpg_pkg::cmd_t  cmd
);
    import ifsfpg_pkg::*;

    assign cmd_push = push && !full;

    always_comb
    begin
        cmd.idx  = draw[15:14];
        cmd.kind = KIND_SHRINK_HALF;
        unique case (map_set)
            MAP_SET_LINE:
            begin
                cmd.idx  = {1'b0, draw[15]};
                cmd.kind = draw[15] ? KIND_LINE_TOP : KIND_SHRINK_HALF;
            end
            MAP_SET_SQUARE:
            begin
                unique case (draw[15:14])
                    2'd0:    cmd.kind = KIND_SHRINK_HALF;
                    2'd1:    cmd.kind = KIND_SQUARE_UP;
                    2'd2:    cmd.kind = KIND_SQUARE_RIGHT;
                    default: cmd.kind = KIND_SQUARE_FLIP;
                endcase
            end
            default:
            begin
                // the unused set code runs the koch curve
                unique case (draw[15:14])
                    2'd0:    cmd.kind = KIND_KOCH_LEFT;
                    2'd1:    cmd.kind = KIND_KOCH_RISE;
                    2'd2:    cmd.kind = KIND_KOCH_FALL;
                    default: cmd.kind = KIND_KOCH_RIGHT;
                endcase
            end
        endcase
    end

endmodule

/* sv/ifsfpg_back.sv */
// back part: point update and pixel scaling
`include "ifs_fractal_point_generator_macros.svh"

module ifsfpg_back #(
    parameter int FRACTION_BITS = ifsfpg_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ifsfpg_pkg::window_t window,
    input  logic                cmd_empty,
    input  ifsfpg_pkg::cmd_t    cmd,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output ifsfpg_pkg::result_t res
);
    import ifsfpg_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int PW = FB + 4;       // point width
    localparam int CW = FB + 2;       // coefficient width
    localparam int MW = CW + PW;      // product width
    localparam int SW = 2 * FB + 8;   // sum width
    localparam int RW = SW - FB;      // rounded width
    localparam int XW = PW + PIXEL_WIDTH - 1;

    localparam longint Q_ONE    = longint'(1) << FB;
    localparam longint Q_HALF   = Q_ONE >>> 1;
    localparam longint Q_THIRD  = (Q_ONE + 1) / 3;
    localparam longint Q_SIXTH  = (Q_ONE + 3) / 6;
    localparam longint Q_TWO_TH = (2 * Q_ONE + 1) / 3;
    localparam longint Q_S      = (64'sd1239850262 + (longint'(1) << (31 - FB))) >>> (32 - FB);

    localparam logic signed [CW-1:0] C_ZERO   = '0;
    localparam logic signed [CW-1:0] C_HALF   = CW'(Q_HALF);
    localparam logic signed [CW-1:0] C_NHALF  = CW'(-Q_HALF);
    localparam logic signed [CW-1:0] C_THIRD  = CW'(Q_THIRD);
    localparam logic signed [CW-1:0] C_SIXTH  = CW'(Q_SIXTH);
    localparam logic signed [CW-1:0] C_TWO_TH = CW'(Q_TWO_TH);
    localparam logic signed [CW-1:0] C_S      = CW'(Q_S);
    localparam logic signed [CW-1:0] C_NS     = CW'(-Q_S);
    localparam logic signed [SW-1:0] ROUND    = SW'(Q_HALF);

    logic signed [PW-1:0] point_x_reg, point_x_next;
    logic signed [PW-1:0] point_y_reg, point_y_next;
    logic [1:0]           idx_reg;
    logic                 v1_reg;
    logic                 advance;

    logic signed [CW-1:0] xa, xb, tx, ya, yb, ty;
    logic signed [MW-1:0] prod_xa, prod_xb, prod_ya, prod_yb;
    logic signed [SW-1:0] sum_x, sum_y;

    function automatic logic [PW-1:0] saturate(input logic [SW-1:0] sum);
        logic [RW-1:0] r;
        r = sum[SW-1:FB];
        if (r[RW-1] && !(&r[RW-1:PW-1]))
        begin
            saturate = {1'b1, {(PW-1){1'b0}}};
        end
        else if (!r[RW-1] && (|r[RW-1:PW-1]))
        begin
            saturate = {1'b0, {(PW-1){1'b1}}};
        end
        else
        begin
            saturate = r[PW-1:0];
        end
    endfunction

    function automatic logic [PIXEL_WIDTH-1:0] to_pixel(
        input logic [PW-1:0]          p,
        input logic [PIXEL_WIDTH-1:0] size
    );
        logic [XW-1:0]          prod;
        logic [XW-FB-1:0]       scaled;
        logic [PIXEL_WIDTH-1:0] lim;
        prod   = XW'(p[PW-2:0]) * XW'(size);
        scaled = prod[XW-1:FB];
        lim    = size - 1'b1;
        if (p[PW-1] || size == '0)
        begin
            to_pixel = '0;
        end
        else if (scaled > (XW-FB)'(lim))
        begin
            to_pixel = lim;
        end
        else
        begin
            to_pixel = scaled[PIXEL_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        xa = C_HALF;
        xb = C_ZERO;
        tx = C_ZERO;
        ya = C_ZERO;
        yb = C_HALF;
        ty = C_ZERO;
        unique case (cmd.kind)
            KIND_SHRINK_HALF: ;
            KIND_LINE_TOP:
            begin
                tx = C_HALF;
                ty = C_HALF;
            end
            KIND_SQUARE_UP:    ty = C_HALF;
            KIND_SQUARE_RIGHT: tx = C_HALF;
            KIND_SQUARE_FLIP:
            begin
                xa = C_NHALF;
                tx = C_HALF;
                yb = C_NHALF;
                ty = C_HALF;
            end
            KIND_KOCH_LEFT:
            begin
                xa = C_THIRD;
                yb = C_THIRD;
            end
            KIND_KOCH_RISE:
            begin
                xa = C_SIXTH;
                xb = C_NS;
                tx = C_THIRD;
                ya = C_S;
                yb = C_SIXTH;
            end
            KIND_KOCH_FALL:
            begin
                xa = C_SIXTH;
                xb = C_S;
                tx = C_HALF;
                ya = C_NS;
                yb = C_SIXTH;
                ty = C_S;
            end
            KIND_KOCH_RIGHT:
            begin
                xa = C_THIRD;
                tx = C_TWO_TH;
                yb = C_THIRD;
            end
            default: ;
        endcase
    end

    assign prod_xa = xa * point_x_reg;
    assign prod_xb = xb * point_y_reg;
    assign prod_ya = ya * point_x_reg;
    assign prod_yb = yb * point_y_reg;

    // one rounding over the full sum of products and translation
    assign sum_x = SW'(prod_xa) + SW'(prod_xb) + (SW'(tx) <<< FB) + ROUND;
    assign sum_y = SW'(prod_ya) + SW'(prod_yb) + (SW'(ty) <<< FB) + ROUND;

    assign point_x_next = saturate(sum_x);
    assign point_y_next = saturate(sum_y);

    // point feeds the pixel scaler, so it moves only if idle or on a transfer out
    assign advance  = !v1_reg || !res_full;
    assign cmd_pop  = advance && !cmd_empty;
    assign res_push = v1_reg && !res_full;

    assign res.pixel_x   = to_pixel(point_x_reg, window.width);
    assign res.pixel_y   = to_pixel(point_y_reg, window.height);
    assign res.map_index = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            v1_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                v1_reg <= !cmd_empty;
            end
            if (cmd_pop)
            begin
                point_x_reg <= point_x_next;
                point_y_reg <= point_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            idx_reg <= cmd.idx;
        end
    end

    `IFSFPG_CHECK_NEXT(a_point_holds, v1_reg && res_full, $stable(point_x_reg) && $stable(point_y_reg))
    `IFSFPG_CHECK_NOW(a_pop_on_advance, cmd_pop, !cmd_empty && (!v1_reg || !res_full))
    `IFSFPG_CHECK_NOW(a_pixel_x_in_window, res_push && window.width != '0, res.pixel_x < window.width)
    `IFSFPG_CHECK_NOW(a_pixel_y_in_window, res_push && window.height != '0, res.pixel_y < window.height)

endmodule

/* sv/ifs_fractal_point_generator.sv */
// top level of the chaos-game point generator
// Chaos-game point generator: every draw pushed in yields exactly one result (pixel_x,
// pixel_y, map_index) in order. The sustained rate is one draw per clock while the result
// side is popped and does not back up; a draw's result reaches the result side through the
// command queue, the point update register and then the result queue.
// The rate is set by the point update loop: the new point depends on the previous one
// through a combinational multiply-add and saturation.
// Configuration writes take effect at once and belong to idle periods only.
module ifs_fractal_point_generator #(
    parameter int FRACTION_BITS = ifsfpg_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [15:0]                            draw,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [ifsfpg_pkg::PIXEL_WIDTH-1:0]     pixel_x,
    output logic [ifsfpg_pkg::PIXEL_WIDTH-1:0]     pixel_y,
    output logic [1:0]                             map_index,
    input  logic                                   cfg_write,
    input  logic [ifsfpg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ifsfpg_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import ifsfpg_pkg::*;

    logic [1:0] map_set_reg;
    window_t    window_reg;

    logic       cmd_push;
    cmd_t       cmd_in;
    logic       cmd_full;
    logic       cmd_empty;
    logic       cmd_pop;
    cmd_t       cmd_out;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    logic       res_push;
    logic       res_full;
    result_t    res_in;
    logic [$bits(result_t)-1:0] res_bits;
    result_t    res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_set_reg       <= RESET_MAP_SET;
            window_reg.width  <= RESET_WINDOW;
            window_reg.height <= RESET_WINDOW;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAP_SET:       map_set_reg       <= cfg_data[1:0];
                REG_WINDOW_WIDTH:  window_reg.width  <= cfg_data;
                REG_WINDOW_HEIGHT: window_reg.height <= cfg_data;
                default: ;
            endcase
        end
    end

    assign full = cmd_full;

    ifsfpg_front u_front (
        .push     (push),
        .full     (cmd_full),
        .draw     (draw),
        .map_set  (map_set_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    ifsfpg_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_bits);

    ifsfpg_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .window    (window_reg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    ifsfpg_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_out   = result_t'(res_bits);
    assign pixel_x   = res_out.pixel_x;
    assign pixel_y   = res_out.pixel_y;
    assign map_index = res_out.map_index;

endmodule

/* test/tb_ifs_fractal_point_generator.sv */
// testbench of the chaos-game point generator: random draws checked against a fixed-point predictor
`timescale 1ns / 1ps

module tb_ifs_fractal_point_generator;
    import ifsfpg_pkg::*;

    localparam int     FRAC         = DEFAULT_FRACTION_BITS;
    localparam longint Q_ONE        = longint'(1) << FRAC;
    localparam longint Q_HALF       = Q_ONE / 2;
    localparam longint Q_THIRD      = (Q_ONE + 1) / 3;
    localparam longint Q_SIXTH      = (Q_ONE + 3) / 6;
    localparam longint Q_TWO_THIRDS = (2 * Q_ONE + 1) / 3;
    // sqrt(3)/6 held with 32 fraction bits, rounded to nearest at FRAC bits
    localparam longint ROOT_Q32     = 64'd1239850262;
    localparam longint Q_ROOT       = (ROOT_Q32 + (longint'(1) << (31 - FRAC))) >> (32 - FRAC);
    localparam longint POS_MAX      = (longint'(1) << (FRAC + 3)) - 1;
    localparam longint POS_MIN      = -(longint'(1) << (FRAC + 3));

    // the one map set code the package leaves unnamed; decodes as the Koch curve
    localparam logic [1:0] MAP_SET_SPARE = 2'd3;

    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int HOLD_AT        = 360;
    localparam int HOLD_CYCLES    = 250;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PRINT_LIMIT    = 100;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [15:0]                draw = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [PIXEL_WIDTH-1:0]     pixel_x;
    logic [PIXEL_WIDTH-1:0]     pixel_y;
    logic [1:0]                 map_index;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;

    // predictor copy of the registers and of the point
    logic [1:0]             model_map_set = RESET_MAP_SET;
    logic [PIXEL_WIDTH-1:0] model_width = RESET_WINDOW;
    logic [PIXEL_WIDTH-1:0] model_height = RESET_WINDOW;
    longint                 pos_x = 0;
    longint                 pos_y = 0;

    map_kind_t square_maps[4] = '{KIND_SHRINK_HALF, KIND_SQUARE_UP,
                                  KIND_SQUARE_RIGHT, KIND_SQUARE_FLIP};
    map_kind_t koch_maps[4]   = '{KIND_KOCH_LEFT, KIND_KOCH_RISE,
                                  KIND_KOCH_FALL, KIND_KOCH_RIGHT};

    logic [15:0] pending_draws[$];
    result_t     expected_pixels[$];

    int          items_queued = 0;
    int          items_taken = 0;
    int          results_done = 0;
    int          idle_odds = 20;
    int          send_gap = 0;
    int          take_gap = 0;
    int          hold_left = 0;
    bit          hold_armed = 1'b1;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    ifs_fractal_point_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .draw      (draw),
        .empty     (empty),
        .pop       (pop),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .map_index (map_index),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sum of products plus translation, rounded half up, saturated to the point range
    function automatic longint next_coord(longint a, longint b, longint t,
                                          longint px, longint py);
        longint v;
        v = (a * px + b * py + t * Q_ONE + Q_HALF) >>> FRAC;
        if (v > POS_MAX)
            v = POS_MAX;
        if (v < POS_MIN)
            v = POS_MIN;
        return v;
    endfunction

    function automatic logic [PIXEL_WIDTH-1:0] pixel_of(longint p, logic [PIXEL_WIDTH-1:0] size);
        longint v;
        if (size == '0 || p < 0)
            return '0;
        v = (p * longint'(size)) >>> FRAC;
        if (v > longint'(size) - 1)
            v = longint'(size) - 1;
        return v[PIXEL_WIDTH-1:0];
    endfunction

    function automatic void advance_point(logic [15:0] d);
        longint     ax, bx, tx, ay, by, ty, nx;
        logic [1:0] sel;
        map_kind_t  kind;
        result_t    r;
        ax = 0; bx = 0; tx = 0; ay = 0; by = 0; ty = 0;
        if (model_map_set == MAP_SET_LINE)
        begin
            sel  = {1'b0, d[15]};
            kind = d[15] ? KIND_LINE_TOP : KIND_SHRINK_HALF;
        end
        else if (model_map_set == MAP_SET_SQUARE)
        begin
            sel  = d[15:14];
            kind = square_maps[sel];
        end
        else
        begin
            sel  = d[15:14];
            kind = koch_maps[sel];
        end
        case (kind)
            KIND_SHRINK_HALF:  begin ax = Q_HALF; by = Q_HALF; end
            KIND_LINE_TOP:     begin ax = Q_HALF; by = Q_HALF; tx = Q_HALF; ty = Q_HALF; end
            KIND_SQUARE_UP:    begin ax = Q_HALF; by = Q_HALF; ty = Q_HALF; end
            KIND_SQUARE_RIGHT: begin ax = Q_HALF; by = Q_HALF; tx = Q_HALF; end
            KIND_SQUARE_FLIP:  begin ax = -Q_HALF; by = -Q_HALF; tx = Q_HALF; ty = Q_HALF; end
            KIND_KOCH_LEFT:    begin ax = Q_THIRD; by = Q_THIRD; end
            KIND_KOCH_RISE:
            begin
                ax = Q_SIXTH; bx = -Q_ROOT; tx = Q_THIRD;
                ay = Q_ROOT;  by = Q_SIXTH;
            end
            KIND_KOCH_FALL:
            begin
                ax = Q_SIXTH; bx = Q_ROOT;  tx = Q_HALF;
                ay = -Q_ROOT; by = Q_SIXTH; ty = Q_ROOT;
            end
            default:           begin ax = Q_THIRD; by = Q_THIRD; tx = Q_TWO_THIRDS; end
        endcase
        nx    = next_coord(ax, bx, tx, pos_x, pos_y);
        pos_y = next_coord(ay, by, ty, pos_x, pos_y);
        pos_x = nx;
        r.pixel_x   = pixel_of(pos_x, model_width);
        r.pixel_y   = pixel_of(pos_y, model_height);
        r.map_index = sel;
        expected_pixels.push_back(r);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // sender: one draw per transfer, random idle bursts between transfers
    always @(posedge clk)
    begin : drive_side
        logic fired;
        if (!rst_n)
        begin
            push     <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            fired = push && !full;
            if (fired)
            begin
                advance_point(draw);
                items_taken <= items_taken + 1;
            end
            if (push && !fired)
            begin
                // blocked by full, keep offering the same draw
            end
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                push     <= 1'b0;
            end
            else if (pending_draws.size() != 0 && $urandom_range(0, 99) >= idle_odds)
            begin
                push <= 1'b1;
                draw <= pending_draws.pop_front();
            end
            else
            begin
                push <= 1'b0;
                if (pending_draws.size() != 0)
                    send_gap <= $urandom_range(0, 15);
            end
        end
    end

    // receiver: checks each result transfer against the oldest prediction
    always @(posedge clk)
    begin : watch_side
        result_t want;
        if (!rst_n)
        begin
            pop      <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results_done <= results_done + 1;
                if (expected_pixels.size() == 0)
                    flag_mismatch("result with nothing pending, pixel_x", pixel_x, 0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.pixel_x)
                        flag_mismatch("pixel_x", pixel_x, want.pixel_x);
                    if (pixel_y !== want.pixel_y)
                        flag_mismatch("pixel_y", pixel_y, want.pixel_y);
                    if (map_index !== want.map_index)
                        flag_mismatch("map_index", map_index, want.map_index);
                end
            end
            if (hold_left != 0)
                pop <= 1'b0;
            else if (take_gap != 0)
            begin
                take_gap <= take_gap - 1;
                pop      <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_odds)
            begin
                pop      <= 1'b0;
                take_gap <= $urandom_range(0, 15);
            end
            else
                pop <= 1'b1;
        end
    end

    // one long receiver hold-off so the block fills and backs up its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && items_taken == HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** ifs_fractal_point_generator: FAILED **");
            $finish;
        end
    end

    task automatic offer_draw(logic [15:0] d);
        pending_draws.push_back(d);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_done != items_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_MAP_SET:       model_map_set = value[1:0];
            REG_WINDOW_WIDTH:  model_width = value;
            REG_WINDOW_HEIGHT: model_height = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [1:0] set, logic [CFG_WIDTH-1:0] w, logic [CFG_WIDTH-1:0] h);
        write_reg(REG_MAP_SET, CFG_WIDTH'(set));
        write_reg(REG_WINDOW_WIDTH, w);
        write_reg(REG_WINDOW_HEIGHT, h);
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 12'd1;
            2:       return 12'd4095;
            3:       return RESET_WINDOW;
            default: return CFG_WIDTH'($urandom_range(1, 4095));
        endcase
    endfunction

    initial
    begin : stimulus
        int         count;
        int         run_len;
        logic [1:0] top;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every Koch map, then map 3 repeatedly to push x onto the window edge
        offer_draw(16'h0000);
        offer_draw(16'h3FFF);
        offer_draw(16'h4000);
        offer_draw(16'h7FFF);
        offer_draw(16'h8000);
        offer_draw(16'hBFFF);
        offer_draw(16'hC000);
        repeat (3) offer_draw(16'hFFFF);
        wait_drained();

        // line set, widest window across, one pixel high
        configure(MAP_SET_LINE, 12'd4095, 12'd1);
        repeat (3) offer_draw(16'hFFFF);
        offer_draw(16'h7FFF);
        offer_draw(16'h8000);
        wait_drained();

        // square set with a zero width window
        configure(MAP_SET_SQUARE, 12'd0, 12'd4095);
        offer_draw(16'h0000);
        offer_draw(16'h4000);
        offer_draw(16'h8000);
        offer_draw(16'hC000);
        offer_draw(16'hFFFF);
        wait_drained();

        // unused set code falls back to Koch
        configure(MAP_SET_SPARE, 12'd1, 12'd2);
        offer_draw(16'h4000);
        offer_draw(16'h8000);
        offer_draw(16'hC000);
        offer_draw(16'h3FFF);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            configure(2'($urandom_range(0, 3)), pick_size(), pick_size());
            if (ph == RANDOM_PHASES - 1 || ph % 3 == 1)
                idle_odds = 0;
            else
                idle_odds = $urandom_range(5, 40);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    offer_draw(16'($urandom));
                    count++;
                end
                else
                begin
                    // runs on one map drive the point into the corners of the attractor
                    top     = 2'($urandom_range(0, 3));
                    run_len = $urandom_range(1, 12);
                    repeat (run_len)
                    begin
                        offer_draw({top, 14'($urandom)});
                        count++;
                    end
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("** ifs_fractal_point_generator: PASSED **");
        else
            $display("** ifs_fractal_point_generator: FAILED **");
        $finish;
    end

endmodule
